// File: design/drbt_pkg.sv
package drbt_pkg;

	// Fixed widths of the access and result fields.
	localparam int LINE_ADDR_W = 40;
	localparam int BANK_NUM_W  = 4;
	localparam int DELAY_W     = 10;
	localparam int TIMING_W    = 8;
	localparam int SHIFT_W     = 4;
	localparam int CNT_W       = 48;
	localparam int SUM_W       = 58;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// Address bits consumed by one divider step.
	localparam int DIV_STEP = 8;

	// Depth of the queue between the front end and the back end.
	localparam int QUEUE_DEPTH = 4;

	// Register file layout.
	localparam int APB_DATA_W = 32;
	localparam int PADDR_W    = 5;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_FIXED_MODE  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PAGE_POLICY = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_LINE_OFFSET = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_FIXED_DELAY = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ACT_DELAY   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_CAS_DELAY   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_PRE_DELAY   = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_BUS_DELAY   = 3'd7;

	// Outcome classes.
	localparam logic [1:0] OUTCOME_HIT      = 2'd0;
	localparam logic [1:0] OUTCOME_CONFLICT = 2'd1;
	localparam logic [1:0] OUTCOME_EMPTY    = 2'd2;
	localparam logic [1:0] OUTCOME_CLOSE    = 2'd3;

	typedef struct packed {
		logic                fixed_mode;
		logic                page_policy;
		logic [SHIFT_W-1:0]  line_offset_bits;
		logic [DELAY_W-1:0]  fixed_delay;
		logic [TIMING_W-1:0] act_delay;
		logic [TIMING_W-1:0] cas_delay;
		logic [TIMING_W-1:0] pre_delay;
		logic [TIMING_W-1:0] bus_delay;
	} drbt_cfg_t;

	localparam drbt_cfg_t CFG_RESET = '{
		fixed_mode:       1'b1,
		page_policy:      1'b0,
		line_offset_bits: 4'd4,
		fixed_delay:      10'd100,
		act_delay:        8'd45,
		cas_delay:        8'd45,
		pre_delay:        8'd45,
		bus_delay:        8'd10
	};

endpackage

// File: design/drbt_req_if.sv
interface drbt_req_if import drbt_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [LINE_ADDR_W-1:0] line_address;
	logic                   is_write;

	modport source (output valid, output line_address, output is_write, input ready);
	modport sink (input valid, input line_address, input is_write, output ready);
endinterface

// File: design/drbt_rsp_if.sv
interface drbt_rsp_if import drbt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [DELAY_W-1:0]    access_delay;
	logic [1:0]            outcome;
	logic [BANK_NUM_W-1:0] bank_number;
	logic [CNT_W-1:0]      read_count;
	logic [SUM_W-1:0]      read_delay_total;
	logic [CNT_W-1:0]      write_count;
	logic [SUM_W-1:0]      write_delay_total;

	modport source (output valid, output access_delay, output outcome, output bank_number,
		output read_count, output read_delay_total, output write_count,
		output write_delay_total, input ready);
	modport sink (input valid, input access_delay, input outcome, input bank_number,
		input read_count, input read_delay_total, input write_count,
		input write_delay_total, output ready);
endinterface

// File: design/drbt_front.sv
module drbt_front import drbt_pkg::*; #(
	parameter int BANKS  = 16,
	parameter int ADDR_W = 40,
	parameter int BANK_W = 4,
	parameter int ROW_W  = 36
) (
	input  logic              clk,
	input  logic              arst_n,
	drbt_req_if.sink          req,
	input  drbt_cfg_t         cfg,
	output logic              push_valid,
	input  logic              push_ready,
	output logic [BANK_W-1:0] push_bank,
	output logic [ROW_W-1:0]  push_row,
	output logic              push_write
);

	localparam bit POW2   = ((BANKS & (BANKS - 1)) == 0);
	localparam int NSTEP  = (ADDR_W + DIV_STEP - 1) / DIV_STEP;
	localparam int DIV_W  = NSTEP * DIV_STEP;
	localparam int STEP_W = $clog2(NSTEP + 1);
	localparam int R_W    = BANK_W + 1;

	logic              full_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DIV_W-1:0]  work_q;
	logic [BANK_W-1:0] rem_q;
	logic              wr_q;

	logic [ADDR_W-1:0] addr_in;
	logic [ADDR_W-1:0] addr_sh;
	logic [DIV_W-1:0]  step_work;
	logic [BANK_W-1:0] step_rem;
	logic              done;
	logic              accept;
	logic              stepping;

	assign addr_in = req.line_address[ADDR_W-1:0];
	assign addr_sh = cfg.fixed_mode ? addr_in : (addr_in >> cfg.line_offset_bits);

	assign done     = full_q && (cnt_q == '0);
	assign stepping = full_q && (cnt_q != '0);
	assign req.ready = !full_q || (done && push_ready);
	assign accept    = req.valid && req.ready;

	// Restoring division by the bank count, several quotient bits per cycle.
	// The work word shifts left; quotient bits enter at its low end.
	always_comb begin
		logic [R_W-1:0]   r;
		logic [DIV_W-1:0] w;
		r = {1'b0, rem_q};
		w = work_q;
		for (int i = 0; i < DIV_STEP; i++) begin
			r = {r[BANK_W-1:0], w[DIV_W-1]};
			w = {w[DIV_W-2:0], 1'b0};
			if (r >= R_W'(BANKS)) begin
				r = r - R_W'(BANKS);
				w[0] = 1'b1;
			end
		end
		step_work = w;
		step_rem  = r[BANK_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			full_q <= 1'b1;
			cnt_q  <= POW2 ? '0 : STEP_W'(NSTEP);
		end else if (stepping) begin
			cnt_q <= cnt_q - 1'b1;
		end else if (done && push_ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			work_q <= DIV_W'(addr_sh);
			rem_q  <= '0;
			wr_q   <= req.is_write;
		end else if (stepping) begin
			work_q <= step_work;
			rem_q  <= step_rem;
		end
	end

	assign push_valid = done;
	assign push_bank  = POW2 ? work_q[BANK_W-1:0] : rem_q;
	assign push_row   = POW2 ? ROW_W'(work_q >> BANK_W) : work_q[ROW_W-1:0];
	assign push_write = wr_q;

endmodule

// File: design/drbt_queue.sv
module drbt_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign in_ready  = (count_q != CNT_W'(DEPTH));
	assign out_valid = (count_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= in_data;
		end
	end

endmodule

// File: design/drbt_back.sv
module drbt_back import drbt_pkg::*; #(
	parameter int BANKS  = 16,
	parameter int BANK_W = 4,
	parameter int ROW_W  = 36
) (
	input  logic              clk,
	input  logic              arst_n,
	input  drbt_cfg_t         cfg,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  logic [BANK_W-1:0] pop_bank,
	input  logic [ROW_W-1:0]  pop_row,
	input  logic              pop_write,
	drbt_rsp_if.source        rsp
);

	logic [ROW_W-1:0]  row_mem [BANKS];
	logic [ROW_W-1:0]  mem_rd_q;
	logic [BANKS-1:0]  open_q;

	logic              vld_s1;
	logic [BANK_W-1:0] bank_s1;
	logic [ROW_W-1:0]  row_s1;
	logic              wr_s1;
	logic              byp_s1;
	logic [ROW_W-1:0]  prev_row_q;

	logic [CNT_W-1:0]  rd_cnt_q;
	logic [SUM_W-1:0]  rd_sum_q;
	logic [CNT_W-1:0]  wr_cnt_q;
	logic [SUM_W-1:0]  wr_sum_q;

	logic              out_vld_q;
	logic [DELAY_W-1:0] out_delay_q;
	logic [1:0]        out_outcome_q;
	logic [BANK_W-1:0] out_bank_q;

	logic              fire;
	logic              load;
	logic [ROW_W-1:0]  open_row;
	logic              bank_open;
	logic              row_match;
	logic [DELAY_W-1:0] d_cb;
	logic [DELAY_W-1:0] d_acb;
	logic [DELAY_W-1:0] d_pacb;
	logic [DELAY_W-1:0] delay;
	logic [1:0]        outcome;
	logic              next_open;
	logic [CNT_W-1:0]  cnt_sel;
	logic [SUM_W-1:0]  sum_sel;
	logic [CNT_W-1:0]  cnt_next;
	logic [SUM_W:0]    sum_wide;
	logic [SUM_W-1:0]  sum_next;

	assign fire      = vld_s1 && (!out_vld_q || rsp.ready);
	assign pop_ready = !vld_s1 || fire;
	assign load      = pop_valid && pop_ready;

	// A bank written in the cycle its successor was read returns the old
	// row from the memory, so the row just written is forwarded instead.
	assign open_row  = byp_s1 ? prev_row_q : mem_rd_q;
	assign bank_open = open_q[bank_s1];
	assign row_match = bank_open && (open_row == row_s1);

	assign d_cb   = DELAY_W'(cfg.cas_delay) + DELAY_W'(cfg.bus_delay);
	assign d_acb  = d_cb + DELAY_W'(cfg.act_delay);
	assign d_pacb = d_acb + DELAY_W'(cfg.pre_delay);

	always_comb begin
		if (cfg.fixed_mode || !cfg.page_policy) begin
			outcome = row_match ? OUTCOME_HIT : (bank_open ? OUTCOME_CONFLICT : OUTCOME_EMPTY);
		end else begin
			outcome = OUTCOME_CLOSE;
		end
		if (cfg.fixed_mode) begin
			delay = cfg.fixed_delay;
		end else begin
			case (outcome)
				OUTCOME_HIT:      delay = d_cb;
				OUTCOME_CONFLICT: delay = d_pacb;
				default:          delay = d_acb;
			endcase
		end
		next_open = cfg.fixed_mode || !cfg.page_policy;
	end

	// Saturating statistics; only the counters of the access direction move.
	assign cnt_sel  = wr_s1 ? wr_cnt_q : rd_cnt_q;
	assign sum_sel  = wr_s1 ? wr_sum_q : rd_sum_q;
	assign cnt_next = (cnt_sel == CNT_MAX) ? cnt_sel : cnt_sel + 1'b1;
	assign sum_wide = {1'b0, sum_sel} + (SUM_W + 1)'(delay);
	assign sum_next = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];

	always_ff @(posedge clk) begin
		if (fire) begin
			row_mem[bank_s1] <= row_s1;
		end
		if (load) begin
			mem_rd_q <= row_mem[pop_bank];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			open_q    <= '0;
			rd_cnt_q  <= '0;
			rd_sum_q  <= '0;
			wr_cnt_q  <= '0;
			wr_sum_q  <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (load) begin
				vld_s1 <= 1'b1;
			end else if (fire) begin
				vld_s1 <= 1'b0;
			end
			if (fire) begin
				open_q[bank_s1] <= next_open;
				if (wr_s1) begin
					wr_cnt_q <= cnt_next;
					wr_sum_q <= sum_next;
				end else begin
					rd_cnt_q <= cnt_next;
					rd_sum_q <= sum_next;
				end
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bank_s1 <= pop_bank;
			row_s1  <= pop_row;
			wr_s1   <= pop_write;
			byp_s1  <= fire && (bank_s1 == pop_bank);
		end
		if (fire) begin
			prev_row_q    <= row_s1;
			out_delay_q   <= delay;
			out_outcome_q <= outcome;
			out_bank_q    <= bank_s1;
		end
	end

	assign rsp.valid             = out_vld_q;
	assign rsp.access_delay      = out_delay_q;
	assign rsp.outcome           = out_outcome_q;
	assign rsp.bank_number       = BANK_NUM_W'(out_bank_q);
	assign rsp.read_count        = rd_cnt_q;
	assign rsp.read_delay_total  = rd_sum_q;
	assign rsp.write_count       = wr_cnt_q;
	assign rsp.write_delay_total = wr_sum_q;

endmodule

// File: design/dram_row_buffer_timing_unit.sv
// DRAM row-buffer timing unit. Each request beat carries a line address and a
// read/write flag; each response beat returns the delay charged for that access,
// its outcome (row hit, row conflict, bank empty or close-page access), the
// bank it selected and the saturating read/write counts and delay sums after
// it. The address is split into bank (modulo BANKS) and row (quotient); in
// row-buffer mode it is first shifted right by line_offset_bits. When BANKS is
// a power of two the split is a bit select and the unit sustains one access
// per cycle unless the response port stalls. Otherwise the front end divides
// by BANKS eight address bits per cycle and takes no new request until it is
// done; the back end still retires one access per cycle unless the response
// port stalls. A request with no division passes the front-end, queue,
// back-end stage and output registers. The open rows live in a small row
// memory with a registered read; open flags are flops cleared by reset, so
// no clearing pass is needed. Registers sit on an APB port at byte address
// 4*index and must be written only while no access is in flight.
module dram_row_buffer_timing_unit import drbt_pkg::*; #(
	parameter int BANKS        = 16,
	parameter int ADDRESS_BITS = 40
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	drbt_req_if.sink              req,
	drbt_rsp_if.source            rsp
);

	// Only the low 40 address bits ever reach the split.
	localparam int ADDR_W    = (ADDRESS_BITS < LINE_ADDR_W) ? ADDRESS_BITS : LINE_ADDR_W;
	localparam int BANK_W    = $clog2(BANKS);
	localparam int FLOOR_LOG = $clog2(BANKS + 1) - 1;
	localparam int ROW_W     = ADDR_W - FLOOR_LOG;
	localparam int ENT_W     = BANK_W + ROW_W + 1;

	drbt_cfg_t             cfg_q;
	logic                  cfg_wr;
	logic [REG_IDX_W-1:0]  reg_idx;

	logic                  fe_valid;
	logic                  fe_ready;
	logic [BANK_W-1:0]     fe_bank;
	logic [ROW_W-1:0]      fe_row;
	logic                  fe_write;
	logic                  be_valid;
	logic                  be_ready;
	logic [ENT_W-1:0]      be_data;

	// Register file. pready is tied high, so every access completes in the
	// access phase.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_FIXED_MODE:  cfg_q.fixed_mode       <= pwdata[0];
				REG_PAGE_POLICY: cfg_q.page_policy      <= pwdata[0];
				REG_LINE_OFFSET: cfg_q.line_offset_bits <= pwdata[SHIFT_W-1:0];
				REG_FIXED_DELAY: cfg_q.fixed_delay      <= pwdata[DELAY_W-1:0];
				REG_ACT_DELAY:   cfg_q.act_delay        <= pwdata[TIMING_W-1:0];
				REG_CAS_DELAY:   cfg_q.cas_delay        <= pwdata[TIMING_W-1:0];
				REG_PRE_DELAY:   cfg_q.pre_delay        <= pwdata[TIMING_W-1:0];
				REG_BUS_DELAY:   cfg_q.bus_delay        <= pwdata[TIMING_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FIXED_MODE:  prdata = APB_DATA_W'(cfg_q.fixed_mode);
			REG_PAGE_POLICY: prdata = APB_DATA_W'(cfg_q.page_policy);
			REG_LINE_OFFSET: prdata = APB_DATA_W'(cfg_q.line_offset_bits);
			REG_FIXED_DELAY: prdata = APB_DATA_W'(cfg_q.fixed_delay);
			REG_ACT_DELAY:   prdata = APB_DATA_W'(cfg_q.act_delay);
			REG_CAS_DELAY:   prdata = APB_DATA_W'(cfg_q.cas_delay);
			REG_PRE_DELAY:   prdata = APB_DATA_W'(cfg_q.pre_delay);
			REG_BUS_DELAY:   prdata = APB_DATA_W'(cfg_q.bus_delay);
			default:         prdata = '0;
		endcase
	end

	// The front end takes request beats and splits each address into bank
	// and row.
	drbt_front #(
		.BANKS  (BANKS),
		.ADDR_W (ADDR_W),
		.BANK_W (BANK_W),
		.ROW_W  (ROW_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg_q),
		.push_valid (fe_valid),
		.push_ready (fe_ready),
		.push_bank  (fe_bank),
		.push_row   (fe_row),
		.push_write (fe_write)
	);

	// The queue lets a stalled response port hold the back end without
	// stopping the front end at once.
	drbt_queue #(
		.WIDTH (ENT_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fe_valid),
		.in_ready  (fe_ready),
		.in_data   ({fe_bank, fe_row, fe_write}),
		.out_valid (be_valid),
		.out_ready (be_ready),
		.out_data  (be_data)
	);

	// The back end looks up the bank, charges the delay, updates the open
	// row state and statistics and drives the response beat.
	drbt_back #(
		.BANKS  (BANKS),
		.BANK_W (BANK_W),
		.ROW_W  (ROW_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (be_valid),
		.pop_ready (be_ready),
		.pop_bank  (be_data[ENT_W-1 -: BANK_W]),
		.pop_row   (be_data[ROW_W:1]),
		.pop_write (be_data[0]),
		.rsp       (rsp)
	);

endmodule
